// ----- rtl/core/psu_pkg.sv -----
package psu_pkg;

   localparam int MAX_ROW_BYTES   = 8192;
   localparam int MAX_PIXEL_BYTES = 8;
   localparam int OP_FIFO_DEPTH   = 4;

   localparam int POS_W      = $clog2(MAX_ROW_BYTES);
   localparam int COL_W      = POS_W + 1;
   localparam int PIX_IDX_W  = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
   localparam int FIFO_PTR_W = $clog2(OP_FIFO_DEPTH);
   localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

   localparam int BPP_W      = 4;
   localparam int ROWLEN_W   = 14;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = ROWLEN_W;

   localparam logic [CSR_IDX_W-1:0] CSR_BYTES_PER_PIXEL = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_BYTES       = 1'd1;

   localparam logic [BPP_W-1:0]    BPP_MAX    = BPP_W'(MAX_PIXEL_BYTES);
   localparam logic [ROWLEN_W-1:0] ROWLEN_MAX = ROWLEN_W'(MAX_ROW_BYTES);

   typedef enum logic [2:0] {
      FILT_NONE  = 3'd0,
      FILT_SUB   = 3'd1,
      FILT_UP    = 3'd2,
      FILT_AVG   = 3'd3,
      FILT_PAETH = 3'd4
   } filter_type_type;

   localparam logic [7:0] FILTER_CODE_MAX = 8'(FILT_PAETH);

   typedef struct packed {
      logic [7:0] data_byte;
      logic       image_start;
   } req_type;

   typedef struct packed {
      logic [7:0] pixel_byte;
      logic       row_end;
      logic       filter_error;
   } rsp_type;

   // one data byte, classified by the front end
   typedef struct packed {
      logic [7:0]       data;
      logic [POS_W-1:0] pos;
      filter_type_type  filt;
      logic             first_row;
      logic             row_start;
      logic             last;
      logic             err;
   } op_type;

   // Paeth predictor: nearest of a, b, c to a+b-c
   function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                             input logic [7:0] c);
      logic signed [9:0] da;
      logic signed [9:0] db;
      logic signed [9:0] dc;
      logic [9:0]        pa;
      logic [9:0]        pb;
      logic [9:0]        pc;
      logic [7:0]        pick;
      da = $signed({2'b00, b}) - $signed({2'b00, c});
      db = $signed({2'b00, a}) - $signed({2'b00, c});
      dc = da + db;
      pa = (da < 0) ? 10'(-da) : 10'(da);
      pb = (db < 0) ? 10'(-db) : 10'(db);
      pc = (dc < 0) ? 10'(-dc) : 10'(dc);
      if (pa <= pb && pa <= pc) begin
         pick = a;
      end else if (pb <= pc) begin
         pick = b;
      end else begin
         pick = c;
      end
      return pick;
   endfunction

endpackage

// ----- rtl/core/png_scanline_unfilter_core.sv -----
// PNG scanline unfilter: one stream byte per beat in, one reconstructed byte per data
// beat out (filter type bytes produce no output). Sustains one byte per cycle while
// rsp_ready holds and the op queue is not full; a data byte enters the 4-entry op
// queue when accepted, is popped into the line-store read stage and then lands in the
// output register (predict/add), which drives rsp_valid. The Sub/Average/Paeth
// left-byte dependency closes through the predictor and adder. The user must write
// bytes_per_pixel and row_bytes via csr only while idle; the block does not enforce it.
module png_scanline_unfilter_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  psu_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output psu_pkg::rsp_type               rsp_data,
   input  logic                           csr_we,
   input  logic [psu_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [psu_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import psu_pkg::*;

   logic                 q_full;
   logic                 q_push;
   op_type               q_push_op;
   logic                 q_pop;
   logic                 q_valid;
   op_type               q_head_op;
   logic [PIX_IDX_W-1:0] bpp_sel;

   psu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_op      (q_push_op),
      .bpp_sel   (bpp_sel)
   );

   psu_op_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_op    (q_push_op),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_op    (q_head_op)
   );

   psu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_op      (q_head_op),
      .q_pop     (q_pop),
      .bpp_sel   (bpp_sel),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef ASSERT_OFF
   a_no_push_when_full : assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("op queue overflow");

   a_start_is_filter_beat : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.image_start) |-> !q_push)
      else $error("image start beat queued as data");

   a_error_zeroes_pixel : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.filter_error) |-> (rsp_data.pixel_byte == 8'd0))
      else $error("pixel not zeroed under filter error");

   a_pop_needs_entry : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from empty op queue");
`endif

endmodule

// ----- rtl/core/psu_front.sv -----
module psu_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  psu_pkg::req_type             req_data,
   input  logic                         csr_we,
   input  logic [psu_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [psu_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                         q_full,
   output logic                         q_push,
   output psu_pkg::op_type              q_op,
   output logic [psu_pkg::PIX_IDX_W-1:0] bpp_sel
);
   import psu_pkg::*;

   logic [BPP_W-1:0]    bpp_ff;
   logic [ROWLEN_W-1:0] rlen_ff;
   logic [COL_W-1:0]    col_ff;
   logic [COL_W-1:0]    col_in;
   filter_type_type     filt_ff;
   filter_type_type     filt_in;
   logic                first_ff;
   logic                first_in;
   logic                err_ff;
   logic                err_in;

   logic [COL_W-1:0]    col_eff;
   logic                first_eff;
   logic                err_eff;
   logic [ROWLEN_W-1:0] rlen_eff;
   logic [POS_W-1:0]    pos;
   logic                last;
   logic                accept;
   logic                is_filter;

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff  <= BPP_W'(1);
         rlen_ff <= ROWLEN_W'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BYTES_PER_PIXEL: bpp_ff  <= csr_wdata[BPP_W-1:0];
            CSR_ROW_BYTES:       rlen_ff <= csr_wdata[ROWLEN_W-1:0];
         endcase
      end
   end

   always_comb begin
      if (bpp_ff == '0) begin
         bpp_sel = '0;
      end else if (bpp_ff > BPP_MAX) begin
         bpp_sel = PIX_IDX_W'(MAX_PIXEL_BYTES - 1);
      end else begin
         bpp_sel = PIX_IDX_W'(bpp_ff - BPP_W'(1));
      end
      if (rlen_ff == '0) begin
         rlen_eff = ROWLEN_W'(1);
      end else if (rlen_ff > ROWLEN_MAX) begin
         rlen_eff = ROWLEN_MAX;
      end else begin
         rlen_eff = rlen_ff;
      end
   end

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      col_eff   = req_data.image_start ? '0 : col_ff;
      first_eff = req_data.image_start | first_ff;
      err_eff   = !req_data.image_start && err_ff;
      is_filter = (col_eff == '0);
      pos       = POS_W'(col_eff - COL_W'(1));
      last      = (ROWLEN_W'(pos) + ROWLEN_W'(1)) >= rlen_eff;

      col_in   = col_ff;
      filt_in  = filt_ff;
      first_in = first_ff;
      err_in   = err_ff;
      if (accept) begin
         first_in = first_eff;
         err_in   = err_eff;
         if (is_filter) begin
            col_in = COL_W'(1);
            if (req_data.data_byte > FILTER_CODE_MAX) begin
               err_in  = 1'b1;
               filt_in = FILT_NONE;
            end else begin
               filt_in = filter_type_type'(req_data.data_byte[2:0]);
            end
         end else if (last) begin
            col_in   = '0;
            first_in = 1'b0;
         end else begin
            col_in = COL_W'(pos) + COL_W'(2);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         filt_ff  <= FILT_NONE;
         first_ff <= 1'b1;
         err_ff   <= 1'b0;
      end else begin
         col_ff   <= col_in;
         filt_ff  <= filt_in;
         first_ff <= first_in;
         err_ff   <= err_in;
      end
   end

   assign q_push = accept && !is_filter;

   always_comb begin
      q_op.data      = req_data.data_byte;
      q_op.pos       = pos;
      q_op.filt      = filt_ff;
      q_op.first_row = first_eff;
      q_op.row_start = (col_eff == COL_W'(1));
      q_op.last      = last;
      q_op.err       = err_eff;
   end

endmodule

// ----- rtl/core/psu_op_fifo.sv -----
module psu_op_fifo (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  psu_pkg::op_type push_op,
   output logic            full,
   input  logic            pop,
   output logic            head_valid,
   output psu_pkg::op_type head_op
);
   import psu_pkg::*;

   op_type                 mem_ff [OP_FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]  wr_ptr_ff;
   logic [FIFO_PTR_W-1:0]  rd_ptr_ff;
   logic [FIFO_CNT_W-1:0]  cnt_ff;
   logic [FIFO_CNT_W-1:0]  cnt_in;

   assign full       = (cnt_ff == FIFO_CNT_W'(OP_FIFO_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_op    = mem_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + FIFO_CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - FIFO_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_PTR_W'(1);
         end
      end
   end

endmodule

// ----- rtl/core/psu_back.sv -----
module psu_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  psu_pkg::op_type               q_op,
   output logic                          q_pop,
   input  logic [psu_pkg::PIX_IDX_W-1:0] bpp_sel,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output psu_pkg::rsp_type              rsp_data
);
   import psu_pkg::*;

   logic [7:0]  line_mem [MAX_ROW_BYTES];
   logic [7:0]  rd_ff;
   logic        byp_ff;
   logic [7:0]  byp_val_ff;

   logic        s1_v_ff;
   logic        s1_v_in;
   op_type      s1_op_ff;

   logic [7:0]  left_ff [MAX_PIXEL_BYTES];
   logic [7:0]  ul_ff   [MAX_PIXEL_BYTES];
   logic [7:0]  left_eff [MAX_PIXEL_BYTES];
   logic [7:0]  ul_eff   [MAX_PIXEL_BYTES];

   logic        out_v_ff;
   logic        out_v_in;
   rsp_type     out_ff;

   logic        s1_adv;
   logic [7:0]  a;
   logic [7:0]  b;
   logic [7:0]  c;
   logic [8:0]  avg_sum;
   logic [7:0]  pred;
   logic [7:0]  val;

   assign s1_adv = s1_v_ff && (!out_v_ff || rsp_ready);
   assign q_pop  = q_valid && (!s1_v_ff || s1_adv);

   always_comb begin
      s1_v_in = s1_v_ff;
      if (!s1_v_ff || s1_adv) begin
         s1_v_in = q_pop;
      end
      out_v_in = out_v_ff;
      if (s1_adv) begin
         out_v_in = 1'b1;
      end else if (rsp_ready) begin
         out_v_in = 1'b0;
      end
   end

   // line store: write of the retiring byte and read of the next one can share an edge,
   // so a same-address read is forwarded from the write
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         line_mem[s1_op_ff.pos] <= val;
      end
      if (q_pop) begin
         rd_ff <= line_mem[q_op.pos];
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_op_ff   <= q_op;
         byp_ff     <= s1_adv && (s1_op_ff.pos == q_op.pos);
         byp_val_ff <= val;
      end
   end

   always_comb begin
      for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
         left_eff[k] = s1_op_ff.row_start ? 8'd0 : left_ff[k];
         ul_eff[k]   = s1_op_ff.row_start ? 8'd0 : ul_ff[k];
      end
      a = left_eff[bpp_sel];
      c = ul_eff[bpp_sel];
      if (s1_op_ff.first_row) begin
         b = 8'd0;
      end else begin
         b = byp_ff ? byp_val_ff : rd_ff;
      end
      avg_sum = {1'b0, a} + {1'b0, b};
      unique case (s1_op_ff.filt)
         FILT_SUB:   pred = a;
         FILT_UP:    pred = b;
         FILT_AVG:   pred = avg_sum[8:1];
         FILT_PAETH: pred = paeth_pick(a, b, c);
         default:    pred = 8'd0;
      endcase
      val = s1_op_ff.data + pred;
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         left_ff[0] <= val;
         ul_ff[0]   <= b;
         for (int k = 1; k < MAX_PIXEL_BYTES; k++) begin
            left_ff[k] <= left_eff[k-1];
            ul_ff[k]   <= ul_eff[k-1];
         end
         out_ff.pixel_byte   <= s1_op_ff.err ? 8'd0 : val;
         out_ff.row_end      <= s1_op_ff.last;
         out_ff.filter_error <= s1_op_ff.err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         s1_v_ff  <= s1_v_in;
         out_v_ff <= out_v_in;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

endmodule
